>>> rtl/obb_pkg.sv
// Package with widths, types and helper functions for the oriented box overlap test.
package obb_pkg;
	localparam int CompBits = 20;
	localparam int AxisFrac = CompBits - 2;
	localparam int WordBits = 3 * CompBits;
	localparam int DiffBits = CompBits + 1;
	localparam int DotBits = 2 * DiffBits;
	localparam int RotBits = DotBits - AxisFrac;
	localparam int SumBits = 2 * RotBits;

	typedef logic signed [CompBits-1:0] comp_t;
	typedef logic signed [DiffBits-1:0] diff_t;
	typedef logic signed [DotBits-1:0] dot_t;
	typedef logic signed [RotBits-1:0] rot_t;
	typedef logic signed [SumBits-1:0] sum_t;

	localparam dot_t RoundHalf = dot_t'(1) <<< (AxisFrac - 1);

	typedef struct packed {
		logic [WordBits-1:0] box_a_center;
		logic [WordBits-1:0] box_a_half_size;
		logic [WordBits-1:0] box_a_axis_x;
		logic [WordBits-1:0] box_a_axis_y;
		logic [WordBits-1:0] box_a_axis_z;
		logic [WordBits-1:0] box_b_center;
		logic [WordBits-1:0] box_b_half_size;
		logic [WordBits-1:0] box_b_axis_x;
		logic [WordBits-1:0] box_b_axis_y;
		logic [WordBits-1:0] box_b_axis_z;
	} obb_in_t;

	typedef struct packed {
		logic overlap;
	} obb_out_t;

	function automatic comp_t get_comp(input logic [WordBits-1:0] w, input int k);
		get_comp = comp_t'(w[k*CompBits +: CompBits]);
	endfunction

	function automatic comp_t clamp_pos(input comp_t v);
		clamp_pos = v[CompBits-1] ? comp_t'(0) : v;
	endfunction

	function automatic dot_t mul_d(input diff_t x, input diff_t y);
		mul_d = dot_t'(x) * dot_t'(y);
	endfunction

	function automatic sum_t mul_s(input rot_t x, input rot_t y);
		mul_s = sum_t'(x) * sum_t'(y);
	endfunction

	function automatic rot_t mag_rot(input rot_t v);
		mag_rot = v[RotBits-1] ? -v : v;
	endfunction

	function automatic sum_t mag_sum(input sum_t v);
		mag_sum = v[SumBits-1] ? -v : v;
	endfunction

	function automatic int wrap3(input int i);
		wrap3 = (i >= 3) ? i - 3 : i;
	endfunction
endpackage

>>> rtl/obb_if.sv
// Valid/ready channel interface that carries one word of a given type.
interface obb_if #(parameter type word_t = logic) (input logic clk);
	logic valid;
	logic ready;
	word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/oriented_box_overlap_test.sv
// Top level of the oriented box overlap test, a pipelined 15-axis separating-axis test.
//
// One box pair is accepted every cycle while the output is not stalled, and its overlap word
// is offered through a seven-stage pipeline: unpacking and the center difference, the raw dot
// products, rounding of rotation and translation, magnitudes, projected products, radius
// and distance sums, and the final compares. A stall on the output holds every stage in
// place; an input word is taken whenever the last stage is empty or being emptied, so
// the input ready follows the output ready within the same cycle.
module oriented_box_overlap_test (
	input logic clk,
	input logic arst_n,
	obb_if.sink in_ch,
	obb_if.source out_ch
);
	import obb_pkg::*;

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic ovl_s7;

	assign adv = !v_s7 || out_ch.ready;
	assign in_ch.ready = adv;
	assign out_ch.valid = v_s7;
	assign out_ch.data.overlap = ovl_s7;

	// Stage 1: unpacked fields and center difference.
	comp_t ha_s1 [3], hb_s1 [3];
	comp_t a_s1 [3][3], b_s1 [3][3];
	diff_t dc_s1 [3];
	// Stage 2: raw dot product terms.
	comp_t ha_s2 [3], hb_s2 [3];
	dot_t rp_s2 [3][3][3];
	dot_t tp_s2 [3][3];
	// Stage 3: rounded rotation and translation.
	comp_t ha_s3 [3], hb_s3 [3];
	rot_t r_s3 [3][3], t_s3 [3];
	// Stage 4: magnitudes.
	rot_t ha_s4 [3], hb_s4 [3];
	rot_t r_s4 [3][3], ar_s4 [3][3], t_s4 [3], at_s4 [3];
	// Stage 5: projected products.
	sum_t hap_s5 [3][3][3], hbp_s5 [3][3][3], trp_s5 [3][3][3];
	sum_t hao_s5 [3], hbo_s5 [3], ato_s5 [3];
	// Stage 6: radii and distances.
	sum_t rad_s6 [15], dst_s6 [15];

	dot_t rs_c [3][3], ts_c [3];
	sum_t rad_c [15], dst_c [15];
	logic sep_c;

	logic [WordBits-1:0] ax [3], bx [3];
	assign ax[0] = in_ch.data.box_a_axis_x;
	assign ax[1] = in_ch.data.box_a_axis_y;
	assign ax[2] = in_ch.data.box_a_axis_z;
	assign bx[0] = in_ch.data.box_b_axis_x;
	assign bx[1] = in_ch.data.box_b_axis_y;
	assign bx[2] = in_ch.data.box_b_axis_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_ch.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				ha_s1[k] <= clamp_pos(get_comp(in_ch.data.box_a_half_size, k));
				hb_s1[k] <= clamp_pos(get_comp(in_ch.data.box_b_half_size, k));
				dc_s1[k] <= diff_t'(get_comp(in_ch.data.box_b_center, k))
					- diff_t'(get_comp(in_ch.data.box_a_center, k));
				for (int i = 0; i < 3; i++) begin
					a_s1[i][k] <= get_comp(ax[i], k);
					b_s1[i][k] <= get_comp(bx[i], k);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ha_s2 <= ha_s1;
			hb_s2 <= hb_s1;
			for (int i = 0; i < 3; i++) begin
				for (int k = 0; k < 3; k++) begin
					tp_s2[i][k] <= mul_d(dc_s1[k], diff_t'(a_s1[i][k]));
					for (int j = 0; j < 3; j++) begin
						rp_s2[i][j][k] <= mul_d(diff_t'(a_s1[i][k]), diff_t'(b_s1[j][k]));
					end
				end
			end
		end
	end

	// Rounding to nearest with ties upward: add half, then shift right arithmetically.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ts_c[i] = tp_s2[i][0] + tp_s2[i][1] + tp_s2[i][2] + RoundHalf;
			for (int j = 0; j < 3; j++) begin
				rs_c[i][j] = rp_s2[i][j][0] + rp_s2[i][j][1] + rp_s2[i][j][2] + RoundHalf;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ha_s3 <= ha_s2;
			hb_s3 <= hb_s2;
			for (int i = 0; i < 3; i++) begin
				t_s3[i] <= rot_t'(ts_c[i] >>> AxisFrac);
				for (int j = 0; j < 3; j++) begin
					r_s3[i][j] <= rot_t'(rs_c[i][j] >>> AxisFrac);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			r_s4 <= r_s3;
			t_s4 <= t_s3;
			for (int i = 0; i < 3; i++) begin
				ha_s4[i] <= rot_t'(ha_s3[i]);
				hb_s4[i] <= rot_t'(hb_s3[i]);
				at_s4[i] <= mag_rot(t_s3[i]);
				for (int j = 0; j < 3; j++) begin
					ar_s4[i][j] <= mag_rot(r_s3[i][j]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				hao_s5[k] <= sum_t'(ha_s4[k]) <<< AxisFrac;
				hbo_s5[k] <= sum_t'(hb_s4[k]) <<< AxisFrac;
				ato_s5[k] <= sum_t'(at_s4[k]) <<< AxisFrac;
				for (int i = 0; i < 3; i++) begin
					for (int j = 0; j < 3; j++) begin
						hap_s5[k][i][j] <= mul_s(ha_s4[k], ar_s4[i][j]);
						hbp_s5[k][i][j] <= mul_s(hb_s4[k], ar_s4[i][j]);
						trp_s5[k][i][j] <= mul_s(t_s4[k], r_s4[i][j]);
					end
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rad_c[i] = hao_s5[i] + hbp_s5[0][i][0] + hbp_s5[1][i][1] + hbp_s5[2][i][2];
			dst_c[i] = ato_s5[i];
			rad_c[3+i] = hbo_s5[i] + hap_s5[0][0][i] + hap_s5[1][1][i] + hap_s5[2][2][i];
			dst_c[3+i] = trp_s5[0][0][i] + trp_s5[1][1][i] + trp_s5[2][2][i];
			for (int j = 0; j < 3; j++) begin
				rad_c[6+3*i+j] = hap_s5[wrap3(i+1)][wrap3(i+2)][j]
					+ hap_s5[wrap3(i+2)][wrap3(i+1)][j]
					+ hbp_s5[wrap3(j+1)][i][wrap3(j+2)]
					+ hbp_s5[wrap3(j+2)][i][wrap3(j+1)];
				dst_c[6+3*i+j] = trp_s5[wrap3(i+2)][wrap3(i+1)][j]
					- trp_s5[wrap3(i+1)][wrap3(i+2)][j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rad_s6 <= rad_c;
			dst_s6 <= dst_c;
		end
	end

	always_comb begin
		sep_c = 1'b0;
		for (int k = 0; k < 15; k++) begin
			if (mag_sum(dst_s6[k]) > rad_s6[k]) sep_c = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ovl_s7 <= !sep_c;
		end
	end

`ifndef SYNTHESIS
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
		else $error("result word changed while stalled");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_ch.valid |-> in_ch.ready)
		else $error("input stalled with empty output");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |=> v_s1 == $past(in_ch.valid))
		else $error("valid bit lost in first stage");
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !$isunknown(out_ch.data))
		else $error("result word is unknown");
`endif
endmodule

>>> verif/oriented_box_overlap_test_tb.sv
// Self-checking testbench for the oriented box overlap test with a scoreboard class.
module oriented_box_overlap_test_tb;
	import obb_pkg::*;

	localparam int Period = 12;
	localparam int Half = Period / 2;
	localparam int RandomPairs = 1400;
	localparam longint One = longint'(1) << AxisFrac;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int mismatch_count = 0;

	obb_if #(.word_t(obb_in_t)) in_ch (clk);
	obb_if #(.word_t(obb_out_t)) out_ch (clk);

	oriented_box_overlap_test uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	always #(Half) clk = ~clk;

	task automatic report(input string what);
		$display("%0t: %s", $realtime, what);
		mismatch_count++;
	endtask

	function automatic longint field(input logic [WordBits-1:0] w, input int k);
		logic signed [CompBits-1:0] c;
		c = w[k*CompBits +: CompBits];
		return longint'(c);
	endfunction

	function automatic longint round_axis(input longint x);
		return (x + (longint'(1) << (AxisFrac - 1))) >>> AxisFrac;
	endfunction

	function automatic longint magnitude(input longint x);
		return x < 0 ? -x : x;
	endfunction

	function automatic logic boxes_touch(input obb_in_t p);
		longint a[3][3], b[3][3], ca[3], cb[3], ha[3], hb[3], t[3];
		longint r[3][3], ar[3][3];
		longint rad, d, acc;
		logic [WordBits-1:0] aw[3], bw[3];
		logic apart;
		int i1, i2, j1, j2;
		aw = '{p.box_a_axis_x, p.box_a_axis_y, p.box_a_axis_z};
		bw = '{p.box_b_axis_x, p.box_b_axis_y, p.box_b_axis_z};
		apart = 1'b0;
		for (int k = 0; k < 3; k++) begin
			ca[k] = field(p.box_a_center, k);
			cb[k] = field(p.box_b_center, k);
			ha[k] = field(p.box_a_half_size, k);
			hb[k] = field(p.box_b_half_size, k);
			if (ha[k] < 0) ha[k] = 0;
			if (hb[k] < 0) hb[k] = 0;
			for (int i = 0; i < 3; i++) begin
				a[i][k] = field(aw[i], k);
				b[i][k] = field(bw[i], k);
			end
		end
		for (int i = 0; i < 3; i++) begin
			acc = 0;
			for (int k = 0; k < 3; k++) acc += (cb[k] - ca[k]) * a[i][k];
			t[i] = round_axis(acc);
			for (int j = 0; j < 3; j++) begin
				acc = 0;
				for (int k = 0; k < 3; k++) acc += a[i][k] * b[j][k];
				r[i][j] = round_axis(acc);
				ar[i][j] = magnitude(r[i][j]);
			end
		end
		for (int i = 0; i < 3; i++) begin
			rad = ha[i] * One + hb[0] * ar[i][0] + hb[1] * ar[i][1] + hb[2] * ar[i][2];
			if (magnitude(t[i]) * One > rad) apart = 1'b1;
		end
		for (int j = 0; j < 3; j++) begin
			rad = hb[j] * One + ha[0] * ar[0][j] + ha[1] * ar[1][j] + ha[2] * ar[2][j];
			d = t[0] * r[0][j] + t[1] * r[1][j] + t[2] * r[2][j];
			if (magnitude(d) > rad) apart = 1'b1;
		end
		for (int i = 0; i < 3; i++) begin
			i1 = (i + 1) % 3;
			i2 = (i + 2) % 3;
			for (int j = 0; j < 3; j++) begin
				j1 = (j + 1) % 3;
				j2 = (j + 2) % 3;
				rad = ha[i1] * ar[i2][j] + ha[i2] * ar[i1][j]
					+ hb[j1] * ar[i][j2] + hb[j2] * ar[i][j1];
				d = t[i2] * r[i1][j] - t[i1] * r[i2][j];
				if (magnitude(d) > rad) apart = 1'b1;
			end
		end
		return !apart;
	endfunction

	class overlap_scoreboard;
		logic expected_flags[$];

		function void note_pair(input obb_in_t p);
			expected_flags.push_back(boxes_touch(p));
		endfunction

		task check_flag(input obb_out_t res);
			logic want;
			if (expected_flags.size() == 0) begin
				report("overlap word arrived with nothing expected");
				return;
			end
			want = expected_flags.pop_front();
			if (res.overlap !== want)
				report($sformatf("overlap is %b, expected %b", res.overlap, want));
		endtask
	endclass

	overlap_scoreboard board = new();

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55) return 0;
		if (roll < 92) return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	function automatic logic [WordBits-1:0] pack3(input longint x, input longint y,
		input longint z);
		logic [CompBits-1:0] cx, cy, cz;
		cx = x[CompBits-1:0];
		cy = y[CompBits-1:0];
		cz = z[CompBits-1:0];
		return {cz, cy, cx};
	endfunction

	function automatic logic [WordBits-1:0] raw_word();
		logic [63:0] r;
		r = {$urandom(), $urandom()};
		return r[WordBits-1:0];
	endfunction

	function automatic longint near(input longint v, input int spread);
		return v + $signed($urandom_range(0, 2 * spread)) - spread;
	endfunction

	// Rotated bases built from a random signed permutation, optionally jittered.
	function automatic void random_basis(output logic [WordBits-1:0] ax[3], input int jitter);
		int perm[3];
		int s, tmp;
		longint v[3];
		perm = '{0, 1, 2};
		for (int i = 2; i > 0; i--) begin
			s = $urandom_range(0, i);
			tmp = perm[i];
			perm[i] = perm[s];
			perm[s] = tmp;
		end
		for (int i = 0; i < 3; i++) begin
			v = '{0, 0, 0};
			v[perm[i]] = $urandom_range(0, 1) ? One : -One;
			for (int k = 0; k < 3; k++) v[k] = near(v[k], jitter);
			ax[i] = pack3(v[0], v[1], v[2]);
		end
	endfunction

	function automatic obb_in_t shaped_pair();
		obb_in_t p;
		logic [WordBits-1:0] ax[3];
		logic [10*WordBits-1:0] bits;
		int mode;
		int reach;
		mode = $urandom_range(0, 9);
		if (mode == 0) begin
			for (int f = 0; f < 10; f++) bits[f*WordBits +: WordBits] = raw_word();
			return obb_in_t'(bits);
		end
		reach = (mode < 5) ? 4000 : 200000;
		p.box_a_center = pack3(near(0, reach), near(0, reach), near(0, reach));
		p.box_b_center = pack3(near(0, reach), near(0, reach), near(0, reach));
		p.box_a_half_size = pack3($urandom_range(0, 3000), $urandom_range(0, 3000),
			$urandom_range(0, 3000));
		p.box_b_half_size = pack3($urandom_range(0, 3000), $urandom_range(0, 3000),
			$urandom_range(0, 3000));
		if (mode == 9) p.box_b_half_size = raw_word();
		random_basis(ax, (mode > 6) ? 100000 : $urandom_range(0, 3000));
		p.box_a_axis_x = ax[0];
		p.box_a_axis_y = ax[1];
		p.box_a_axis_z = ax[2];
		random_basis(ax, (mode == 8) ? 100000 : $urandom_range(0, 3000));
		p.box_b_axis_x = ax[0];
		p.box_b_axis_y = ax[1];
		p.box_b_axis_z = ax[2];
		return p;
	endfunction

	task automatic send_pair(input obb_in_t p);
		repeat (pick_gap()) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= p;
		do @(posedge clk); while (!in_ch.ready);
		board.note_pair(p);
	endtask

	task automatic directed_pairs();
		obb_in_t p;
		logic [WordBits-1:0] unit3[3];
		logic [WordBits-1:0] ones, top, bottom;
		unit3 = '{pack3(One, 0, 0), pack3(0, One, 0), pack3(0, 0, One)};
		ones = '1;
		top = pack3(-(longint'(1) << (CompBits - 1)), -(longint'(1) << (CompBits - 1)),
			-(longint'(1) << (CompBits - 1)));
		bottom = pack3((longint'(1) << (CompBits - 1)) - 1,
			(longint'(1) << (CompBits - 1)) - 1, (longint'(1) << (CompBits - 1)) - 1);
		p = '{pack3(0, 0, 0), pack3(256, 256, 256), unit3[0], unit3[1], unit3[2],
			pack3(512, 0, 0), pack3(256, 256, 256), unit3[0], unit3[1], unit3[2]};
		send_pair(p);
		p.box_b_center = pack3(513, 0, 0);
		send_pair(p);
		p.box_b_center = pack3(0, -512, 0);
		send_pair(p);
		p.box_b_center = pack3(0, 0, 600);
		p.box_a_half_size = top;
		send_pair(p);
		p.box_a_half_size = bottom;
		p.box_b_center = top;
		p.box_a_center = bottom;
		send_pair(p);
		p.box_a_half_size = pack3(256, 256, 256);
		p.box_b_axis_x = pack3(185364, 185364, 0);
		p.box_b_axis_y = pack3(-185364, 185364, 0);
		p.box_b_center = pack3(600, 600, 0);
		p.box_a_center = pack3(0, 0, 0);
		send_pair(p);
		p.box_b_axis_x = pack3(3 * One, -One, 7);
		send_pair(p);
		p.box_a_axis_y = top;
		p.box_b_axis_z = bottom;
		send_pair(p);
		send_pair(obb_in_t'({10{ones}}));
		p = '0;
		send_pair(p);
		send_pair(obb_in_t'({5{top, bottom}}));
		send_pair(obb_in_t'({5{bottom, top}}));
		for (int i = 0; i < 8; i++) begin
			p = shaped_pair();
			p.box_a_center[WordBits-1 -: 4] = 4'hf;
			send_pair(p);
		end
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_pairs();
		for (int n = 0; n < RandomPairs; n++) send_pair(shaped_pair());
		in_ch.valid <= 1'b0;
		while (board.expected_flags.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = ($urandom_range(0, 9) < 3) ? pick_gap() : 0;
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			@(posedge clk);
			if (out_ch.valid && out_ch.ready) board.check_flag(out_ch.data);
		end
	end

	initial begin
		#(Period * 400000);
		$display("Mismatches found");
		$finish;
	end
endmodule
